### hw/rtl/tsth_pkg.sv
package tsth_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int TAB_STOP      = 8;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int PHASE_W       = (TAB_STOP > 2) ? $clog2(TAB_STOP) : 1;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_AW       = $clog2(FIFO_DEPTH);

  localparam logic [15:0] COL_MAX = 16'hFFFF;
  localparam logic [PHASE_W-1:0] SAT_PHASE = PHASE_W'((32'hFFFE) % TAB_STOP);
  localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(TAB_STOP - 1);

  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_VT    = 8'd11;
  localparam logic [7:0] CH_FF    = 8'd12;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;

  typedef struct packed {
    logic        has_char;
    logic [7:0]  char_code;
    logic        token_end;
    logic [15:0] token_id;
  } in_item_t;

  typedef struct packed {
    logic [31:0] line_total;
    logic [15:0] column_now;
    logic [31:0] word_total;
    logic [31:0] byte_total;
    logic [31:0] id_count;
    logic        table_full;
  } out_item_t;

  // text statistics done, id still to be counted
  typedef struct packed {
    logic [31:0] line_total;
    logic [15:0] column_now;
    logic [31:0] word_total;
    logic [31:0] byte_total;
    logic        token_end;
    logic [15:0] token_id;
  } stats_item_t;

  typedef struct packed {
    logic        push;
    stats_item_t item;
  } push_t;

  typedef struct packed {
    logic        ready;
    stats_item_t item;
  } head_t;

  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    sat_inc32 = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic is_white(input logic [7:0] c);
    is_white = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) ||
               (c == CH_FF) || (c == CH_CR);
  endfunction

endpackage

### hw/rtl/tsth_ram.sv
module tsth_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/tsth_front.sv
module tsth_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  tsth_pkg::in_item_t in_data,
  input  logic              q_full,
  output tsth_pkg::push_t   q_push
);
  import tsth_pkg::*;

  logic [31:0]        line_reg, line_next;
  logic [15:0]        column_reg, column_next;
  logic [PHASE_W-1:0] phase, phase_next;
  logic [31:0]        word_reg, word_next;
  logic [31:0]        byte_reg, byte_next;
  logic               prev_space, prev_space_next;
  logic               sp;
  logic [16:0]        tab_col;
  logic               take;

  assign in_stall = q_full;
  assign take     = in_valid && !q_full;

  always_comb begin
    line_next       = line_reg;
    column_next     = column_reg;
    phase_next      = phase;
    word_next       = word_reg;
    byte_next       = byte_reg;
    prev_space_next = prev_space;
    sp              = is_white(in_data.char_code);
    tab_col         = (column_reg == 16'd0) ? 17'(TAB_STOP + 1)
                    : 17'(column_reg) + 17'(TAB_STOP) - 17'(phase);
    if (in_data.has_char) begin
      if (in_data.char_code == CH_LF || in_data.char_code == CH_CR) begin
        line_next   = sat_inc32(line_reg);
        column_next = 16'd0;
        phase_next  = '0;
      end else if (in_data.char_code == CH_TAB) begin
        if (tab_col > 17'(COL_MAX)) begin
          column_next = COL_MAX;
          phase_next  = SAT_PHASE;
        end else begin
          column_next = tab_col[15:0];
          phase_next  = '0;
        end
      end else if (column_reg != COL_MAX) begin
        column_next = column_reg + 16'd1;
        if (column_reg == 16'd0 || phase == LAST_PHASE) begin
          phase_next = '0;
        end else begin
          phase_next = phase + PHASE_W'(1);
        end
      end
      if (sp && !prev_space) begin
        word_next = sat_inc32(word_reg);
      end
      byte_next       = sat_inc32(byte_reg);
      prev_space_next = sp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_reg   <= '0;
      column_reg <= '0;
      phase      <= '0;
      word_reg   <= '0;
      byte_reg   <= '0;
      prev_space <= 1'b0;
    end else if (take) begin
      line_reg   <= line_next;
      column_reg <= column_next;
      phase      <= phase_next;
      word_reg   <= word_next;
      byte_reg   <= byte_next;
      prev_space <= prev_space_next;
    end
  end

  always_comb begin
    q_push.push            = take;
    q_push.item.line_total = line_next;
    q_push.item.column_now = column_next;
    q_push.item.word_total = word_next;
    q_push.item.byte_total = byte_next;
    q_push.item.token_end  = in_data.token_end;
    q_push.item.token_id   = in_data.token_id;
  end

endmodule

### hw/rtl/tsth_fifo.sv
module tsth_fifo (
  input  logic            clk,
  input  logic            rst,
  input  tsth_pkg::push_t q_push,
  output logic            q_full,
  output tsth_pkg::head_t q_head,
  input  logic            q_pop
);
  import tsth_pkg::*;

  stats_item_t        slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   fill;
  logic               do_pop;

  assign q_full       = (fill == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign q_head.ready = (fill != '0);
  assign q_head.item  = slots[rd_ptr];
  assign do_pop       = q_pop && q_head.ready;

  always_ff @(posedge clk) begin
    if (q_push.push) begin
      slots[wr_ptr] <= q_push.item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (q_push.push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      if (q_push.push && !do_pop) begin
        fill <= fill + (FIFO_AW + 1)'(1);
      end else if (do_pop && !q_push.push) begin
        fill <= fill - (FIFO_AW + 1)'(1);
      end
    end
  end

endmodule

### hw/rtl/tsth_back.sv
module tsth_back (
  input  logic               clk,
  input  logic               rst,
  input  tsth_pkg::head_t    q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output tsth_pkg::out_item_t out_data
);
  import tsth_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_CMP  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t      state, state_next;
  stats_item_t cur, cur_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] used, used_next;
  logic [31:0] cnt, cnt_next;
  logic        full, full_next;
  logic        res_valid, res_valid_next;
  out_item_t   res, res_next;

  logic             id_we, hit_we;
  logic [IDX_W-1:0] waddr;
  logic [15:0]      id_wdata, id_rdata;
  logic [31:0]      hit_wdata, hit_rdata, hit_inc;
  logic             table_free, res_free;

  tsth_ram #(.WIDTH(16), .DEPTH(TABLE_ENTRIES)) u_id_ram (
    .clk   (clk),
    .we    (id_we),
    .waddr (waddr),
    .wdata (id_wdata),
    .raddr (idx),
    .rdata (id_rdata)
  );

  tsth_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_hit_ram (
    .clk   (clk),
    .we    (hit_we),
    .waddr (waddr),
    .wdata (hit_wdata),
    .raddr (idx),
    .rdata (hit_rdata)
  );

  assign table_free = (used != CNT_W'(TABLE_ENTRIES));
  assign res_free   = !res_valid || !out_stall;
  assign hit_inc    = sat_inc32(hit_rdata);

  always_comb begin
    state_next     = state;
    cur_next       = cur;
    idx_next       = idx;
    used_next      = used;
    cnt_next       = cnt;
    full_next      = full;
    res_valid_next = res_valid && out_stall;
    res_next       = res;
    q_pop          = 1'b0;
    id_we          = 1'b0;
    hit_we         = 1'b0;
    waddr          = idx;
    id_wdata       = cur.token_id;
    hit_wdata      = 32'd1;

    case (state)
      ST_IDLE: begin
        if (q_head.ready) begin
          q_pop     = 1'b1;
          cur_next  = q_head.item;
          cnt_next  = 32'd0;
          full_next = 1'b0;
          idx_next  = '0;
          if (!q_head.item.token_end) begin
            state_next = ST_DONE;
          end else if (used == '0) begin
            // empty table: first id goes straight in
            id_we      = 1'b1;
            hit_we     = 1'b1;
            waddr      = '0;
            id_wdata   = q_head.item.token_id;
            used_next  = CNT_W'(1);
            cnt_next   = 32'd1;
            state_next = ST_DONE;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (id_rdata == cur.token_id) begin
          hit_we     = 1'b1;
          hit_wdata  = hit_inc;
          cnt_next   = hit_inc;
          state_next = ST_DONE;
        end else if (CNT_W'(idx) == used - CNT_W'(1)) begin
          if (table_free) begin
            id_we     = 1'b1;
            hit_we    = 1'b1;
            waddr     = used[IDX_W-1:0];
            used_next = used + CNT_W'(1);
            cnt_next  = 32'd1;
          end else begin
            full_next = 1'b1;
          end
          state_next = ST_DONE;
        end else begin
          idx_next   = idx + IDX_W'(1);
          state_next = ST_READ;
        end
      end
      ST_DONE: begin
        if (res_free) begin
          res_valid_next      = 1'b1;
          res_next.line_total = cur.line_total;
          res_next.column_now = cur.column_now;
          res_next.word_total = cur.word_total;
          res_next.byte_total = cur.byte_total;
          res_next.id_count   = cnt;
          res_next.table_full = full;
          state_next          = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      used      <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      used      <= used_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur  <= cur_next;
    idx  <= idx_next;
    cnt  <= cnt_next;
    full <= full_next;
    res  <= res_next;
  end

  assign out_valid = res_valid;
  assign out_data  = res;

endmodule

### hw/rtl/text_stats_token_histogram.sv
// channel   direction  payload      handshake
// in        to block   in_item_t    in_valid / in_stall
// out       from block out_item_t   out_valid / out_stall
//
// the front takes one character request per cycle while its queue has room
// an item without token_end, or the first id, passes through the queue slot, ST_DONE and the result register
// an id lookup scans the stored entries in order through ST_READ and ST_CMP, up to TABLE_ENTRIES of them
// rst is synchronous; the id table is valid up to its fill count, so no clearing pass
// a stalled output holds its result; the queue keeps taking requests until it is full
module text_stats_token_histogram (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  tsth_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tsth_pkg::out_item_t out_data
);
  import tsth_pkg::*;

  push_t q_push;
  head_t q_head;
  logic  q_full;
  logic  q_pop;

  tsth_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push)
  );

  tsth_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .q_push (q_push),
    .q_full (q_full),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  tsth_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### hw/rtl/tsth_checker.sv
module tsth_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input tsth_pkg::out_item_t out_data
);
  import tsth_pkg::*;

  logic [31:0] last_bytes;
  logic [31:0] last_lines;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_bytes <= '0;
      last_lines <= '0;
    end else if (out_valid && !out_stall) begin
      last_bytes <= out_data.byte_total;
      last_lines <= out_data.line_total;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown straight after reset");

  a_full_no_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.table_full |-> out_data.id_count == 32'd0)
    else $error("dropped id reported a count");

  a_totals_grow: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.byte_total >= last_bytes && out_data.line_total >= last_lines)
    else $error("totals went backwards");

  a_words_bounded: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.word_total <= out_data.byte_total)
    else $error("more words than bytes");

endmodule

bind text_stats_token_histogram tsth_checker u_tsth_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
